FILE: design/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_ZERO = 3'd1,
		MODE_DEC  = 3'd2,
		MODE_HEX  = 3'd3,
		MODE_OCT  = 3'd4,
		MODE_BIN  = 3'd5
	} ils_mode_t;

	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_HEX = 2'd1;
	localparam logic [1:0] RADIX_OCT = 2'd2;
	localparam logic [1:0] RADIX_BIN = 2'd3;

	localparam int unsigned VALUE_W = 31;
	localparam int unsigned PROD_W  = VALUE_W + 5;

	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_1   = 8'h31;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] CH_UA  = 8'h41;
	localparam logic [7:0] CH_UF  = 8'h46;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LB  = 8'h62;
	localparam logic [7:0] CH_LF  = 8'h66;
	localparam logic [7:0] CH_LX  = 8'h78;
	localparam logic [7:0] CH_USC = 8'h5f;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_text;
	} ils_in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         radix;
		logic               is_big;
	} ils_out_t;

	typedef struct packed {
		ils_mode_t          mode;
		logic [VALUE_W-1:0] acc;
		logic               ovf;
	} ils_state_t;

	// A lone leading zero reports as octal.
	function automatic logic [1:0] radix_of(ils_mode_t m);
		logic [1:0] r;
		case (m)
			MODE_DEC: r = RADIX_DEC;
			MODE_HEX: r = RADIX_HEX;
			MODE_BIN: r = RADIX_BIN;
			default:  r = RADIX_OCT;
		endcase
		return r;
	endfunction

endpackage

FILE: design/ils_step.sv
`timescale 1ns / 1ps

module ils_step import ils_pkg::*; (
	input  ils_state_t cur,
	input  ils_in_t    item,
	output ils_state_t nxt,
	output logic       emit,
	output ils_out_t   res
);

	logic [7:0]        c;
	logic              is_num;
	logic              is_lhex;
	logic              is_uhex;
	logic              is_usc;
	logic [4:0]        dval;
	logic              in_base;
	ils_mode_t         m;
	logic [PROD_W-1:0] acc_w;
	logic [PROD_W-1:0] scaled;
	logic [PROD_W-1:0] prod;
	logic              work;
	logic              from_idle;

	assign c       = item.ch;
	assign is_num  = (c >= CH_0) && (c <= CH_9);
	assign is_lhex = (c >= CH_LA) && (c <= CH_LF);
	assign is_uhex = (c >= CH_UA) && (c <= CH_UF);
	assign is_usc  = (c == CH_USC);

	always_comb begin
		if (is_num) begin
			dval = 5'(c - CH_0);
		end else if (is_lhex) begin
			dval = 5'(c - CH_LA + 8'd10);
		end else begin
			dval = 5'(c - CH_UA + 8'd10);
		end
	end

	// Mode after the prefix decision: anything but x or b after a zero is octal.
	always_comb begin
		if (cur.mode == MODE_ZERO) begin
			m = MODE_OCT;
		end else begin
			m = cur.mode;
		end
	end

	always_comb begin
		case (m)
			MODE_DEC: in_base = is_num && (dval < 5'd10);
			MODE_HEX: in_base = is_num || is_lhex || is_uhex;
			MODE_OCT: in_base = is_num && (dval < 5'd8);
			default:  in_base = is_num && (dval < 5'd2);
		endcase
	end

	assign acc_w = PROD_W'(cur.acc);

	always_comb begin
		case (m)
			MODE_DEC: scaled = (acc_w << 3) + (acc_w << 1);
			MODE_HEX: scaled = acc_w << 4;
			MODE_OCT: scaled = acc_w << 3;
			default:  scaled = acc_w << 1;
		endcase
	end

	assign prod = scaled + PROD_W'(dval);

	always_comb begin
		nxt       = cur;
		emit      = 1'b0;
		res.value = cur.ovf ? '0 : cur.acc;
		res.radix = radix_of(m);
		res.is_big = cur.ovf;
		work      = 1'b0;
		from_idle = 1'b0;
		if (item.end_of_text) begin
			emit      = (cur.mode != MODE_IDLE);
			res.radix = radix_of(cur.mode);
			nxt.mode  = MODE_IDLE;
			nxt.acc   = '0;
			nxt.ovf   = 1'b0;
		end else begin
			from_idle = (cur.mode == MODE_IDLE);
			work      = !from_idle;
			if (cur.mode == MODE_ZERO && c == CH_LX) begin
				nxt.mode = MODE_HEX;
				work     = 1'b0;
			end else if (cur.mode == MODE_ZERO && c == CH_LB) begin
				nxt.mode = MODE_BIN;
				work     = 1'b0;
			end
			if (work) begin
				if (is_usc && m != MODE_BIN) begin
					nxt.mode = m;
				end else if (in_base) begin
					nxt.mode = m;
					if (!cur.ovf) begin
						if (|prod[PROD_W-1:VALUE_W]) begin
							nxt.ovf = 1'b1;
							nxt.acc = '0;
						end else begin
							nxt.acc = prod[VALUE_W-1:0];
						end
					end
				end else begin
					emit      = 1'b1;
					from_idle = 1'b1;
				end
			end
			if (from_idle) begin
				nxt.mode = MODE_IDLE;
				nxt.acc  = '0;
				nxt.ovf  = 1'b0;
				if (c == CH_0) begin
					nxt.mode = MODE_ZERO;
				end else if (c >= CH_1 && c <= CH_9) begin
					nxt.mode = MODE_DEC;
					nxt.acc  = VALUE_W'(dval);
				end
			end
		end
	end

endmodule

FILE: design/integer_literal_scanner_unit.sv
`timescale 1ns / 1ps
// A result is registered when the beat ending its literal leaves the input register; that
// beat is held there while the result register is full and stalled. Throughput: one character
// beat per cycle otherwise; the scan state update is a single shift-add and compare between the
// input register and the state and result registers. Reset (arst_n low, asynchronous)
// empties the input and result stages and returns the scanner to idle with a cleared
// accumulator and overflow flag.

module integer_literal_scanner_unit import ils_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     src_valid,
	output logic     src_stall,
	input  ils_in_t  src_data,
	output logic     res_valid,
	input  logic     res_stall,
	output ils_out_t res_data
);

	// Input register: one character waits here while the scan state is updated.
	logic       valid_s1;
	ils_in_t    item_s1;

	// Scan state carried from one character to the next.
	ils_state_t state_q;

	// Result register, which decouples the consumer's stall from the scanner.
	logic       res_valid_q;
	ils_out_t   res_data_q;

	ils_state_t state_nxt;
	logic       emit;
	ils_out_t   res_nxt;
	logic       out_free;
	logic       adv;

	ils_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res_nxt)
	);

	// The result register can take a new result when it is empty or being drained.
	// A character that produces no result moves on regardless of the output side.
	assign out_free  = !res_valid_q || !res_stall;
	assign adv       = valid_s1 && (!emit || out_free);
	assign src_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			state_q.mode  <= MODE_IDLE;
			state_q.acc   <= '0;
			state_q.ovf   <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (!src_stall) begin
				valid_s1 <= src_valid;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
			if (adv && emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset; their valid flags qualify them.
	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_data;
		end
		if (adv && emit) begin
			res_data_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

// Character-stream bench for the integer literal scanner. A queue of character beats
// is filled up front, first with a short hand-written text that walks the corner cases
// and then with random literals in all four radixes. A clocked driver feeds those beats
// into the source channel. On every accepted beat it runs the bench's own scanner, which
// queues the literal that the beat completes, if any. A clocked monitor takes result
// beats with random stalls and compares each one field by field against the oldest
// queued literal.
module tb import ils_pkg::*;;

	localparam int DIGIT_SKIP = 16;
	localparam int DIGIT_STOP = 17;
	localparam int CYCLE_LIMIT = 200000;
	localparam int INPUT_BEATS = 1500;
	localparam longint unsigned VALUE_MAX = 64'h7fff_ffff;
	localparam string SEPARATORS = " ,;)+-\n";

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     src_valid = 1'b0;
	logic     src_stall;
	ils_in_t  src_data = '0;
	logic     res_valid;
	logic     res_stall = 1'b0;
	ils_out_t res_data;

	// Character beats still to be sent, and literals still to be received.
	ils_in_t  char_queue[$];
	ils_out_t lit_expected[$];

	// The bench's own copy of the scanner state.
	ils_mode_t          lex_mode = MODE_IDLE;
	logic [VALUE_W-1:0] lex_acc = '0;
	logic               lex_big = 1'b0;

	// Idle and stall bookkeeping. The calm counters hold a run of beats with no waiting.
	int src_gap = 0;
	int src_calm = 0;
	int res_wait = 0;
	int res_calm = 0;

	int mismatch_count = 0;
	int cycle_count = 0;

	integer_literal_scanner_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data(src_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Scanner prediction
	// ------------------------------------------------------------------

	function automatic int unsigned radix_base(ils_mode_t m);
		case (m)
			MODE_DEC: return 10;
			MODE_HEX: return 16;
			MODE_OCT: return 8;
			default:  return 2;
		endcase
	endfunction

	// Digit value of a character in the given mode. An underscore is skipped everywhere
	// except in binary, where it ends the literal like any other non-digit.
	function automatic int digit_value(ils_mode_t m, logic [7:0] c);
		int d;
		d = DIGIT_STOP;
		if (c >= CH_0 && c <= CH_9)
			d = int'(c - CH_0);
		else if (c >= CH_LA && c <= CH_LF)
			d = int'(c - CH_LA) + 10;
		else if (c >= CH_UA && c <= CH_UF)
			d = int'(c - CH_UA) + 10;
		else if (c == CH_USC)
			return (m == MODE_BIN) ? DIGIT_STOP : DIGIT_SKIP;
		if (d != DIGIT_STOP && d >= int'(radix_base(m)))
			d = DIGIT_STOP;
		return d;
	endfunction

	// Queue the literal being scanned and go back to idle. A bare leading zero
	// has not picked a radix yet, so it reports as octal.
	task automatic close_literal();
		ils_out_t lit;
		lit.value = lex_big ? '0 : lex_acc;
		case (lex_mode)
			MODE_DEC: lit.radix = RADIX_DEC;
			MODE_HEX: lit.radix = RADIX_HEX;
			MODE_BIN: lit.radix = RADIX_BIN;
			default:  lit.radix = RADIX_OCT;
		endcase
		lit.is_big = lex_big;
		lit_expected.push_back(lit);
		lex_mode = MODE_IDLE;
		lex_acc = '0;
		lex_big = 1'b0;
	endtask

	task automatic scan_beat(input ils_in_t beat);
		int d;
		longint unsigned grown;
		// End of text flushes a pending literal and ignores the character.
		if (beat.end_of_text) begin
			if (lex_mode != MODE_IDLE)
				close_literal();
			return;
		end
		// After a leading zero only a lowercase x or b picks hex or binary.
		// Anything else makes it octal and is then handled as an octal character.
		if (lex_mode == MODE_ZERO) begin
			if (beat.ch == CH_LX) begin
				lex_mode = MODE_HEX;
				return;
			end
			if (beat.ch == CH_LB) begin
				lex_mode = MODE_BIN;
				return;
			end
			lex_mode = MODE_OCT;
		end
		if (lex_mode != MODE_IDLE) begin
			d = digit_value(lex_mode, beat.ch);
			if (d == DIGIT_SKIP)
				return;
			if (d != DIGIT_STOP) begin
				// Overflow is exact: the full product is compared against the largest value,
				// and the accumulator stays at zero once the literal has become a bignum.
				if (!lex_big) begin
					grown = longint'(lex_acc) * radix_base(lex_mode) + longint'(d);
					if (grown > VALUE_MAX) begin
						lex_big = 1'b1;
						lex_acc = '0;
					end else begin
						lex_acc = VALUE_W'(grown);
					end
				end
				return;
			end
			// The terminator ends the literal and is then looked at again from idle.
			close_literal();
		end
		if (beat.ch == CH_0) begin
			lex_mode = MODE_ZERO;
			lex_acc = '0;
		end else if (beat.ch >= CH_1 && beat.ch <= CH_9) begin
			lex_mode = MODE_DEC;
			lex_acc = VALUE_W'(beat.ch - CH_0);
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic check_literal(input ils_out_t got);
		ils_out_t want;
		if (lit_expected.size() == 0) begin
			report_mismatch($sformatf("result beat with no literal pending (value %0d)",
				got.value));
			return;
		end
		want = lit_expected.pop_front();
		if (got.value !== want.value)
			report_mismatch($sformatf("value: got %0d, expected %0d", got.value, want.value));
		if (got.radix !== want.radix)
			report_mismatch($sformatf("radix: got %0d, expected %0d", got.radix, want.radix));
		if (got.is_big !== want.is_big)
			report_mismatch($sformatf("is_big: got %0b, expected %0b", got.is_big, want.is_big));
	endtask

	// How many cycles a side waits before its next beat. Now and then a calm run starts,
	// so that the block also sees long stretches at full rate.
	function automatic int draw_wait(inout int calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	// ------------------------------------------------------------------
	// Source driver
	// ------------------------------------------------------------------

	// A beat is taken at an edge where valid is high and stall is low. The scanner model
	// advances right there, so expectations line up with the order the block sees.
	// While stalled, valid and data are held. Otherwise the driver either idles for the
	// gap drawn for this beat or presents the next character. Valid gets one assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (src_valid && !src_stall) begin
				scan_beat(src_data);
				src_gap = draw_wait(src_calm);
			end
			if (!(src_valid && src_stall)) begin
				if (src_gap != 0) begin
					src_gap--;
					src_valid <= 1'b0;
				end else if (char_queue.size() != 0) begin
					src_data <= char_queue.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------

	// After each result beat the monitor draws a stall length and holds stall high for that
	// many cycles. The stall may fall while the block is busy or has nothing to send.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_wait = 0;
		end else begin
			if (res_valid && !res_stall) begin
				check_literal(res_data);
				res_wait = draw_wait(res_calm);
			end
			if (res_wait != 0) begin
				res_wait--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_char(input logic [7:0] c, input logic eot);
		ils_in_t beat;
		beat.ch = c;
		beat.end_of_text = eot;
		char_queue.push_back(beat);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0);
	endtask

	// End of text carries a random byte, which the block must ignore.
	task automatic push_eot();
		push_char(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// One literal in a random radix. Most are short. Some are long enough to overflow,
	// and some land within a few counts of the largest value that still fits.
	// Underscores are sprinkled in after the prefix of all but binary literals, hex letters
	// come in either case, and a random terminator follows.
	task automatic push_random_literal();
		logic [1:0]      form;
		int unsigned     bits;
		int unsigned     lead;
		longint unsigned v;
		string           s;
		logic [7:0]      c;
		form = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0, 1:    bits = $urandom_range(28, 40);
			2:       bits = 0;
			default: bits = $urandom_range(1, 16);
		endcase
		v = {$urandom, $urandom};
		// A zero bit count picks a value straddling the largest value that fits.
		if (bits == 0)
			v = 64'h8000_0000 - 4 + (v & 7);
		else
			v = v >> (64 - bits);
		case (form)
			RADIX_DEC: begin
				s = $sformatf("%0d", v);
				lead = 1;
			end
			RADIX_HEX: begin
				s = $sformatf("0x%0h", v);
				lead = 2;
			end
			RADIX_OCT: begin
				s = $sformatf("0%0o", v);
				lead = 1;
			end
			default: begin
				s = $sformatf("0b%0b", v);
				lead = 2;
			end
		endcase
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (form == RADIX_HEX && i >= 2 && c >= CH_LA && c <= CH_LF &&
				$urandom_range(0, 1) == 1)
				c = c - CH_LA + CH_UA;
			push_char(c, 1'b0);
			if (form != RADIX_BIN && i + 1 >= lead && $urandom_range(0, 9) == 0)
				push_char(CH_USC, 1'b0);
		end
		case ($urandom_range(0, 9))
			0, 1: push_eot();
			2:    push_char(8'($urandom_range(0, 255)), 1'b0);
			// Sometimes the next literal follows with no separator at all.
			3:    ;
			4:    push_char(CH_USC, 1'b0);
			// An out-of-radix character ends the literal; a stray digit also starts a new one.
			5: begin
				case (form)
					RADIX_BIN: push_char(CH_0 + 8'($urandom_range(2, 9)), 1'b0);
					RADIX_OCT: push_char(CH_0 + 8'($urandom_range(8, 9)), 1'b0);
					default:   push_char(CH_LF + 8'($urandom_range(1, 20)), 1'b0);
				endcase
			end
			default: push_char(SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)], 1'b0);
		endcase
	endtask

	initial begin
		// Hand-written opening. Bytes at both ends of the range are ignored while idle,
		// and end of text while idle must produce nothing.
		push_char(8'h00, 1'b0);
		push_char(8'hff, 1'b0);
		push_eot();
		// A lone zero closed by end of text reports octal zero.
		push_text("0");
		push_eot();
		// Empty hex prefix closed by a terminator, then empty binary prefix closed by end of text.
		push_text("0x;");
		push_text("0b");
		push_char(8'hff, 1'b1);
		// An uppercase X is not a prefix, so the zero closes as octal and the X is dropped.
		push_text("0X1 ");
		// Digits outside the radix end octal and binary literals and start decimals.
		// An underscore after a leading zero is skipped.
		push_text("08 0b2 0_7");
		push_eot();

		// Random text: mostly well-formed literals, with some noise bytes, stray end-of-text
		// beats and bare prefixes mixed in between them.
		while (char_queue.size() < INPUT_BEATS) begin
			case ($urandom_range(0, 19))
				0:       repeat ($urandom_range(1, 4)) push_char(8'($urandom_range(0, 255)), 1'b0);
				1:       push_eot();
				2:       push_text($urandom_range(0, 1) ? "0x" : "0b");
				default: ;
			endcase
			push_random_literal();
		end
		push_eot();

		// Release reset away from the rising edge so that the first sampled edge is clean.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every character beat has gone in and every literal has come out.
		// Then allow a few more cycles for any stray result beat to show up.
		while (char_queue.size() != 0 || src_valid || lit_expected.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog against a hung handshake or a dropped result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

endmodule
